### src/tdt_pkg.sv
// Package for the thermistor divider temperature unit.
// Shared types, register indexes and fixed-point constants; no dependencies.
`default_nettype none

package tdt_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned SAMPLE_W        = 12;
  localparam int unsigned SUM_W           = 20;
  localparam int unsigned OHMS_W          = 26;
  localparam int unsigned R_W             = 33;
  localparam int unsigned LOG_W           = 30;
  localparam int unsigned DVD_W           = 57;
  localparam int unsigned DVS_W           = 47;
  localparam int unsigned STEP_W          = 6;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [63:0] InvT0Full = ((64'd1 << 40) * 64'd20 + 64'd2981) / 64'd5963;
  localparam logic [48:0] INV_T0_Q40 = InvT0Full[48:0];
  localparam logic [63:0] ZeroCFull = ((64'd5463 << 16) + 64'd10) / 64'd20;
  localparam logic [57:0] ZERO_C_Q16 = ZeroCFull[57:0];
  localparam logic [19:0] RAIL_MARGIN_MV = 20'd100;

  typedef enum logic [2:0] {
    REG_HIGH_SIDE    = 3'd0,
    REG_SUPPLY_MV    = 3'd1,
    REG_BETA_COEF    = 3'd2,
    REG_NOMINAL_OHMS = 3'd3,
    REG_SERIES_OHMS  = 3'd4,
    REG_SAMPLE_COUNT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic        high_side;
    logic [12:0] supply_mv;
    logic [13:0] beta_coef;
    logic [19:0] nominal_ohms;
    logic [19:0] series_ohms;
    logic [7:0]  sample_count;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_ACC     = 4'd1,
    OP_CHECK_V = 4'd2,
    OP_CHECK_R = 4'd3,
    OP_LOGN    = 4'd4,
    OP_LNMUL   = 4'd5,
    OP_START_Q = 4'd6,
    OP_CALC_D  = 4'd7,
    OP_FIN     = 4'd8
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic finish;
    logic div_busy;
    logic log_busy;
    logic v_bad;
    logic r_zero;
    logic d_nonpos;
  } status_t;

endpackage

`default_nettype wire

### src/tdt_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Dividend is left aligned; steps sets how many bits are used. Uses tdt_pkg.
`default_nettype none

module tdt_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [tdt_pkg::STEP_W-1:0]      steps_i,
  input  wire logic [tdt_pkg::DVD_W-1:0]       dividend_i,
  input  wire logic [tdt_pkg::DVS_W-1:0]       divisor_i,
  output logic                                 busy_o,
  output logic [tdt_pkg::DVD_W-1:0]            quotient_o
);

  logic [tdt_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [tdt_pkg::DVD_W-1:0]  dvd_q, quo_q;
  logic [tdt_pkg::DVS_W-1:0]  dvs_q, rem_q;
  logic [tdt_pkg::DVS_W:0]    rem_sh, rem_sub;
  logic                       ge;

  assign rem_sh  = {rem_q, dvd_q[tdt_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = steps_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - tdt_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[tdt_pkg::DVD_W-2:0], 1'b0};
      rem_q <= ge ? rem_sub[tdt_pkg::DVS_W-1:0] : rem_sh[tdt_pkg::DVS_W-1:0];
      quo_q <= {quo_q[tdt_pkg::DVD_W-2:0], ge};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### src/tdt_log2.sv
// Iterative log2 in Q24: normalize one bit per cycle, then 24 squaring steps.
// One 32x32 multiplier. Uses tdt_pkg.
`default_nettype none

module tdt_log2 (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tdt_pkg::R_W-1:0]     x_i,
  output logic                             busy_o,
  output logic [tdt_pkg::LOG_W-1:0]        result_o
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lstate_e;

  lstate_e                   state_q, state_d;
  logic [tdt_pkg::R_W-1:0]   xn_q;
  logic [5:0]                n_q;
  logic [31:0]               m_q;
  logic [23:0]               frac_q;
  logic [4:0]                it_q;
  logic [63:0]               sq;
  logic [32:0]               sq_sh;

  assign sq    = 64'(m_q) * 64'(m_q);
  assign sq_sh = sq[63:31];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (start_i) state_d = L_NORM;
      L_NORM: if (xn_q[tdt_pkg::R_W-1]) state_d = L_SQ;
      L_SQ:   if (it_q == 5'd1) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          xn_q   <= (x_i == '0) ? tdt_pkg::R_W'(1) : x_i;
          n_q    <= 6'(tdt_pkg::R_W - 1);
          frac_q <= '0;
        end
      end
      L_NORM: begin
        if (xn_q[tdt_pkg::R_W-1]) begin
          m_q  <= xn_q[tdt_pkg::R_W-1:1];
          it_q <= 5'd24;
        end else begin
          xn_q <= {xn_q[tdt_pkg::R_W-2:0], 1'b0};
          n_q  <= n_q - 6'd1;
        end
      end
      L_SQ: begin
        // square stays in [1,4) of the Q31 scale; renormalize into [1,2)
        m_q    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        frac_q <= {frac_q[22:0], sq_sh[32]};
        it_q   <= it_q - 5'd1;
      end
      default: ;
    endcase
  end

  assign busy_o   = state_q != L_IDLE;
  assign result_o = {n_q, frac_q};

endmodule

`default_nettype wire

### src/tdt_datapath.sv
// Datapath: sample accumulator, shared divider and log2 unit, result registers.
// Driven by op commands from tdt_ctrl; uses tdt_pkg, tdt_div, tdt_log2.
`default_nettype none

module tdt_datapath #(
  parameter int unsigned SampleBits = tdt_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire tdt_pkg::cfg_t                   cfg_i,
  input  wire tdt_pkg::cmd_t                   cmd_i,
  input  wire logic [tdt_pkg::SAMPLE_W-1:0]    sample_mv_i,
  output tdt_pkg::status_t                     status_o,
  output logic signed [7:0]                    temp_c_o,
  output logic                                 invalid_o,
  output logic [11:0]                          mean_mv_o,
  output logic [tdt_pkg::OHMS_W-1:0]           thermistor_ohms_o
);

  localparam logic [31:0] SampleMask = (32'd1 << SampleBits) - 32'd1;

  logic [tdt_pkg::SUM_W-1:0]   sum_q, sum_nx, samp;
  logic [tdt_pkg::SUM_W:0]     sum_add;
  logic [7:0]                  taken_q, taken_nx;

  logic                        div_start;
  logic [tdt_pkg::STEP_W-1:0]  div_steps;
  logic [tdt_pkg::DVD_W-1:0]   div_dvd, quo;
  logic [tdt_pkg::DVS_W-1:0]   div_dvs;
  logic                        div_busy;

  logic                        log_start;
  logic [tdt_pkg::R_W-1:0]     log_x;
  logic [tdt_pkg::LOG_W-1:0]   log_res;
  logic                        log_busy;

  logic [19:0]                 v;
  logic [12:0]                 v13, den, numf;
  logic [tdt_pkg::R_W-1:0]     prod, r;
  logic                        v_bad;

  logic [tdt_pkg::LOG_W-1:0]   lr_q, mag;
  logic                        neg_q, neg;
  logic [59:0]                 ln_full;
  logic [tdt_pkg::LOG_W-1:0]   ln_q;
  logic [13:0]                 beta;
  logic [19:0]                 nominal;
  logic [48:0]                 dq;
  logic                        d_nonpos;

  logic signed [57:0]          c;
  logic [57:0]                 cmag;
  logic [41:0]                 w;
  logic signed [7:0]           deg;

  logic signed [7:0]           temp_q;
  logic                        inv_q;
  logic [11:0]                 mean_q;
  logic [tdt_pkg::OHMS_W-1:0]  ohms_q;

  assign samp     = tdt_pkg::SUM_W'(sample_mv_i) & SampleMask[tdt_pkg::SUM_W-1:0];
  assign sum_add  = {1'b0, sum_q} + {1'b0, samp};
  assign sum_nx   = sum_add[tdt_pkg::SUM_W] ? '1 : sum_add[tdt_pkg::SUM_W-1:0];
  assign taken_nx = taken_q + 8'd1;

  assign beta    = (cfg_i.beta_coef == '0) ? 14'd1 : cfg_i.beta_coef;
  assign nominal = (cfg_i.nominal_ohms == '0) ? 20'd1 : cfg_i.nominal_ohms;

  // mean checks and divider operands for the resistance
  assign v     = quo[19:0];
  assign v13   = v[12:0];
  assign v_bad = (v == '0) || (v >= 20'(cfg_i.supply_mv)) ||
                 (cfg_i.high_side ? (v < tdt_pkg::RAIL_MARGIN_MV)
                                  : (v + tdt_pkg::RAIL_MARGIN_MV > 20'(cfg_i.supply_mv)));
  assign den   = cfg_i.high_side ? v13 : cfg_i.supply_mv - v13;
  assign numf  = cfg_i.high_side ? cfg_i.supply_mv - v13 : v13;
  assign prod  = tdt_pkg::R_W'(cfg_i.series_ohms) * tdt_pkg::R_W'(numf);
  assign r     = quo[tdt_pkg::R_W-1:0];

  assign neg     = lr_q < log_res;
  assign mag     = neg ? log_res - lr_q : lr_q - log_res;
  assign ln_full = 60'(mag) * 60'(tdt_pkg::LN2_Q30);

  assign dq       = neg_q ? tdt_pkg::INV_T0_Q40 - 49'(quo[45:0])
                          : tdt_pkg::INV_T0_Q40 + 49'(quo[45:0]);
  assign d_nonpos = dq[48] || (dq == '0);

  assign c    = $signed({1'b0, quo}) - $signed(tdt_pkg::ZERO_C_Q16);
  assign cmag = c[57] ? 58'(-c) : 58'(c);
  assign w    = cmag[57:16];
  always_comb begin
    if (w > 42'd127) begin
      deg = c[57] ? -8'sd127 : 8'sd127;
    end else begin
      deg = c[57] ? -$signed(w[7:0]) : $signed(w[7:0]);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_steps = '0;
    div_dvd   = '0;
    div_dvs   = '0;
    log_start = 1'b0;
    log_x     = '0;
    unique case (cmd_i.op)
      tdt_pkg::OP_ACC: begin
        div_start = (cfg_i.sample_count != '0) && (taken_nx >= cfg_i.sample_count);
        div_steps = 6'd20;
        div_dvd   = {sum_nx, 37'd0};
        div_dvs   = tdt_pkg::DVS_W'(taken_nx);
      end
      tdt_pkg::OP_CHECK_V: begin
        div_start = !v_bad;
        div_steps = 6'd33;
        div_dvd   = {prod, 24'd0};
        div_dvs   = tdt_pkg::DVS_W'(den);
      end
      tdt_pkg::OP_CHECK_R: begin
        log_start = r != '0;
        log_x     = r;
      end
      tdt_pkg::OP_LOGN: begin
        log_start = 1'b1;
        log_x     = tdt_pkg::R_W'(nominal);
      end
      tdt_pkg::OP_START_Q: begin
        div_start = 1'b1;
        div_steps = 6'd46;
        div_dvd   = {ln_q, 27'd0};
        div_dvs   = tdt_pkg::DVS_W'(beta);
      end
      tdt_pkg::OP_CALC_D: begin
        div_start = !d_nonpos;
        div_steps = 6'd57;
        div_dvd   = {1'b1, 56'd0};
        div_dvs   = dq[46:0];
      end
      default: ;
    endcase
  end

  tdt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  tdt_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .x_i      (log_x),
    .busy_o   (log_busy),
    .result_o (log_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      taken_q <= '0;
    end else if (cmd_i.op == tdt_pkg::OP_ACC) begin
      if (cfg_i.sample_count == '0 || taken_nx >= cfg_i.sample_count) begin
        sum_q   <= '0;
        taken_q <= '0;
      end else begin
        sum_q   <= sum_nx;
        taken_q <= taken_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      tdt_pkg::OP_ACC: begin
        if (cfg_i.sample_count == '0) begin
          temp_q <= -8'sd128;
          inv_q  <= 1'b1;
          mean_q <= '0;
          ohms_q <= '0;
        end
      end
      tdt_pkg::OP_CHECK_V: begin
        mean_q <= v[11:0];
        if (v_bad) begin
          temp_q <= -8'sd128;
          inv_q  <= 1'b1;
          ohms_q <= '0;
        end
      end
      tdt_pkg::OP_CHECK_R: begin
        ohms_q <= (r[tdt_pkg::R_W-1:tdt_pkg::OHMS_W] != '0) ? '1 : r[tdt_pkg::OHMS_W-1:0];
        if (r == '0) begin
          temp_q <= -8'sd128;
          inv_q  <= 1'b1;
        end
      end
      tdt_pkg::OP_LOGN: lr_q <= log_res;
      tdt_pkg::OP_LNMUL: begin
        neg_q <= neg;
        ln_q  <= ln_full[59:30];
      end
      tdt_pkg::OP_CALC_D: begin
        if (d_nonpos) begin
          temp_q <= 8'sd127;
          inv_q  <= 1'b0;
        end
      end
      tdt_pkg::OP_FIN: begin
        temp_q <= deg;
        inv_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.cnt_zero = cfg_i.sample_count == '0;
    status_o.finish   = taken_nx >= cfg_i.sample_count;
    status_o.div_busy = div_busy;
    status_o.log_busy = log_busy;
    status_o.v_bad    = v_bad;
    status_o.r_zero   = r == '0;
    status_o.d_nonpos = d_nonpos;
  end

  assign temp_c_o          = temp_q;
  assign invalid_o         = inv_q;
  assign mean_mv_o         = mean_q;
  assign thermistor_ohms_o = ohms_q;

endmodule

`default_nettype wire

### src/tdt_ctrl.sv
// Controller FSM: sequences accumulate, mean, resistance, logs, beta solve.
// Talks to tdt_datapath through cmd_t/status_t from tdt_pkg.
`default_nettype none

module tdt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire tdt_pkg::status_t  status_i,
  output tdt_pkg::cmd_t          cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MEAN   = 9'b000000010,
    S_RDIV   = 9'b000000100,
    S_LOGR   = 9'b000001000,
    S_LOGN   = 9'b000010000,
    S_QSTART = 9'b000100000,
    S_QDIV   = 9'b001000000,
    S_TDIV   = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = tdt_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = tdt_pkg::OP_ACC;
          if (status_i.cnt_zero) state_d = S_EMIT;
          else if (status_i.finish) state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        if (!status_i.div_busy) begin
          cmd_o.op = tdt_pkg::OP_CHECK_V;
          state_d  = status_i.v_bad ? S_EMIT : S_RDIV;
        end
      end
      S_RDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.op = tdt_pkg::OP_CHECK_R;
          state_d  = status_i.r_zero ? S_EMIT : S_LOGR;
        end
      end
      S_LOGR: begin
        if (!status_i.log_busy) begin
          cmd_o.op = tdt_pkg::OP_LOGN;
          state_d  = S_LOGN;
        end
      end
      S_LOGN: begin
        if (!status_i.log_busy) begin
          cmd_o.op = tdt_pkg::OP_LNMUL;
          state_d  = S_QSTART;
        end
      end
      S_QSTART: begin
        cmd_o.op = tdt_pkg::OP_START_Q;
        state_d  = S_QDIV;
      end
      S_QDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.op = tdt_pkg::OP_CALC_D;
          state_d  = status_i.d_nonpos ? S_EMIT : S_TDIV;
        end
      end
      S_TDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.op = tdt_pkg::OP_FIN;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_EMIT;

endmodule

`default_nettype wire

### src/thermistor_divider_temperature_unit.sv
// NTC divider thermometer: averages samples, solves the divider, beta equation.
// A sample that does not end a reading is taken and busy stays low;
// a final sample gives done_o after the mean divide, the resistance divide, two
// log2 runs and the two beta divides, or earlier when a check ends the reading;
// zero sample_count gives done_o the next cycle. Next transfer the cycle after
// done_o; the receiver cannot stall. Async reset restores defaults.
`default_nettype none

module thermistor_divider_temperature_unit #(
  parameter int unsigned SampleBits = tdt_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tdt_pkg::SAMPLE_W-1:0]  sample_mv_i,
  output logic                               done_o,
  output logic signed [7:0]                  temp_c_o,
  output logic                               invalid_o,
  output logic [11:0]                        mean_mv_o,
  output logic [tdt_pkg::OHMS_W-1:0]         thermistor_ohms_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [4:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  tdt_pkg::cfg_t    cfg_q;
  tdt_pkg::cmd_t    cmd;
  tdt_pkg::status_t status;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_side    <= 1'b0;
      cfg_q.supply_mv    <= 13'd3300;
      cfg_q.beta_coef    <= 14'd3950;
      cfg_q.nominal_ohms <= 20'd10000;
      cfg_q.series_ohms  <= 20'd10000;
      cfg_q.sample_count <= 8'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        tdt_pkg::REG_HIGH_SIDE:    cfg_q.high_side    <= pwdata[0];
        tdt_pkg::REG_SUPPLY_MV:    cfg_q.supply_mv    <= pwdata[12:0];
        tdt_pkg::REG_BETA_COEF:    cfg_q.beta_coef    <= pwdata[13:0];
        tdt_pkg::REG_NOMINAL_OHMS: cfg_q.nominal_ohms <= pwdata[19:0];
        tdt_pkg::REG_SERIES_OHMS:  cfg_q.series_ohms  <= pwdata[19:0];
        tdt_pkg::REG_SAMPLE_COUNT: cfg_q.sample_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tdt_pkg::REG_HIGH_SIDE:    prdata = 32'(cfg_q.high_side);
      tdt_pkg::REG_SUPPLY_MV:    prdata = 32'(cfg_q.supply_mv);
      tdt_pkg::REG_BETA_COEF:    prdata = 32'(cfg_q.beta_coef);
      tdt_pkg::REG_NOMINAL_OHMS: prdata = 32'(cfg_q.nominal_ohms);
      tdt_pkg::REG_SERIES_OHMS:  prdata = 32'(cfg_q.series_ohms);
      tdt_pkg::REG_SAMPLE_COUNT: prdata = 32'(cfg_q.sample_count);
      default:                   prdata = '0;
    endcase
  end

  tdt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  tdt_datapath #(
    .SampleBits (SampleBits)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .sample_mv_i       (sample_mv_i),
    .status_o          (status),
    .temp_c_o          (temp_c_o),
    .invalid_o         (invalid_o),
    .mean_mv_o         (mean_mv_o),
    .thermistor_ohms_o (thermistor_ohms_o)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside a busy reading");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o) else $error("no return to idle after result");
  a_inv_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && invalid_o |-> temp_c_o == -8'sd128) else $error("invalid without marker");
  a_inv_ohms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && invalid_o |-> thermistor_ohms_o == '0) else $error("invalid with ohms");
`endif

endmodule

`default_nettype wire
